### design/ccrf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccrf_pkg
// Shared types, widths and constants of the causal convolution residual fit
// unit.
// ----------------------------------------------------------------------------
package ccrf_pkg;

  // Default depth of the model history store.
  localparam int MAX_SAMPLES_DEF = 1024;
  // Tap positions that tap_index can reach; taps beyond read as zero.
  localparam int TAP_REACH = 1024;

  localparam int TAP_W   = 16;
  localparam int MODEL_W = 16;
  localparam int MEAS_W  = 24;
  localparam int TIDX_W  = 10;
  localparam int CONV_W  = 24;
  localparam int ACC_W   = 63;
  localparam int CNT_W   = 11;
  localparam int WIN_W   = 10;
  localparam int SHIFT_W = 4;
  // At most TAP_REACH nonzero products of 2^30 each, plus sign.
  localparam int SUM_W   = 43;
  localparam int SQ_W    = 2 * (CONV_W + 1);

  localparam int CONV_MAX = 8388607;
  localparam int CONV_MIN = -8388608;
  localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'(CONV_MAX);
  localparam logic signed [SUM_W-1:0] SUM_LO = SUM_W'(CONV_MIN);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIN_START  = 2'd0,
    CFG_WIN_END    = 2'd1,
    CFG_FRAC_SHIFT = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [WIN_W-1:0]   win_start;
    logic [WIN_W-1:0]   win_end;
    logic [SHIFT_W-1:0] frac_shift;
  } cfg_t;

  // One classified input beat as it travels from front to back.
  typedef struct packed {
    logic                      is_tap;
    logic                      tap_ok;
    logic [TIDX_W-1:0]         tap_addr;
    logic signed [TAP_W-1:0]   tap_value;
    logic signed [MODEL_W-1:0] model;
    logic signed [MEAS_W-1:0]  meas;
    logic                      last;
  } cmd_t;

  function automatic int tap_depth(int max_samples);
    return (max_samples < TAP_REACH) ? max_samples : TAP_REACH;
  endfunction

endpackage

### design/ccrf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccrf_if
// Valid/ready channels of the causal convolution residual fit unit: input
// beats, result beats and configuration writes.
// ----------------------------------------------------------------------------
interface ccrf_in_if import ccrf_pkg::*; ;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [TIDX_W-1:0]         tap_index;
  logic signed [TAP_W-1:0]   tap_value;
  logic signed [MODEL_W-1:0] model_sample;
  logic signed [MEAS_W-1:0]  measured_sample;
  logic                      last_sample;

  modport source (
    output valid, kind, tap_index, tap_value, model_sample, measured_sample,
           last_sample,
    input  ready
  );
  modport sink (
    input  valid, kind, tap_index, tap_value, model_sample, measured_sample,
           last_sample,
    output ready
  );
endinterface

interface ccrf_out_if import ccrf_pkg::*; ;
  logic                     valid;
  logic                     ready;
  logic signed [CONV_W-1:0] conv_value;
  logic                     in_window;
  logic [ACC_W-1:0]         residual_sum;
  logic [CNT_W-1:0]         window_count;
  logic                     conv_saturated;
  logic                     pass_end;

  modport source (
    output valid, conv_value, in_window, residual_sum, window_count,
           conv_saturated, pass_end,
    input  ready
  );
  modport sink (
    input  valid, conv_value, in_window, residual_sum, window_count,
           conv_saturated, pass_end,
    output ready
  );
endinterface

interface ccrf_cfg_if import ccrf_pkg::*; ;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface

### design/causal_convolution_residual_fit_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// causal_convolution_residual_fit_unit
// Causal convolution of a model stream with a stored template, with a running
// sum of squared residuals against a measured stream.
// ----------------------------------------------------------------------------
// Load the template with kind 0 beats, then stream sample pairs with kind 1
// beats; each sample pair returns one result beat and a sample beat with
// last_sample set closes the pass and clears the index and sums. A tap load
// leaves the back end idle and is written as the back end takes it from the
// queue. A sample whose index is below MAX_SAMPLES holds the back end while
// it is taken from the queue, runs through the single multiply-accumulate that
// reads one tap and one history entry per cycle, drains that pipeline and
// passes the scale, difference, square and emit states. A sample past the end
// of the history goes straight to the emit state. A stalled result beat holds
// the back end until it is taken. A two-entry queue after the input port and
// a result register let new beats arrive while a result waits. Configuration
// writes are taken at any time but should only be made while no sample is in
// flight.
module causal_convolution_residual_fit_unit import ccrf_pkg::*; #(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ccrf_in_if.sink    smp_i,
  ccrf_out_if.source res_o,
  ccrf_cfg_if.sink   cfg_i
);

  cfg_t cfg_q;
  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.win_start  <= '0;
      cfg_q.win_end    <= {WIN_W{1'b1}};
      cfg_q.frac_shift <= SHIFT_W'(12);
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        CFG_WIN_START:  cfg_q.win_start  <= cfg_i.wdata[WIN_W-1:0];
        CFG_WIN_END:    cfg_q.win_end    <= cfg_i.wdata[WIN_W-1:0];
        CFG_FRAC_SHIFT: cfg_q.frac_shift <= cfg_i.wdata[SHIFT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ccrf_front #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .smp_i      (smp_i),
    .cmd_valid_o(cmd_valid),
    .cmd_ready_i(cmd_ready),
    .cmd_o      (cmd)
  );

  ccrf_back #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_valid_i(cmd_valid),
    .cmd_ready_o(cmd_ready),
    .cmd_i      (cmd),
    .res_o      (res_o)
  );

  // A clipped result sits exactly on one of the two range limits.
  a_sat_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.conv_saturated |->
      (res_o.conv_value == CONV_W'(CONV_MAX)) ||
      (res_o.conv_value == CONV_W'(CONV_MIN)))
    else $error("saturated result not at a range limit");

  a_window_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.in_window |-> res_o.window_count != '0)
    else $error("window beat with zero window count");

  // Sum and count are cleared together, so no residual without a count.
  a_sum_needs_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.window_count == '0) |-> res_o.residual_sum == '0)
    else $error("residual sum without counted samples");

  a_queue_from_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(cmd_valid) |-> $past(smp_i.valid && smp_i.ready))
    else $error("queue filled without an input beat");

endmodule

### design/ccrf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccrf_front
// Accepts input beats, decodes them into tap loads or sample pairs and holds
// them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module ccrf_front import ccrf_pkg::*; #(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ccrf_in_if.sink    smp_i,
  output logic       cmd_valid_o,
  input  logic       cmd_ready_i,
  output cmd_t       cmd_o
);

  localparam int QDepth = 2;

  cmd_t       q_mem [QDepth];
  cmd_t       cmd_n;
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign smp_i.ready = (cnt_q != 2'(QDepth));
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_mem[rd_ptr_q];

  assign push = smp_i.valid && smp_i.ready;
  assign pop  = cmd_valid_o && cmd_ready_i;

  always_comb begin
    cmd_n.is_tap    = ~smp_i.kind;
    // Loads past the end of the tap store are dropped by the back end.
    cmd_n.tap_ok    = (32'(smp_i.tap_index) < tap_depth(MAX_SAMPLES));
    cmd_n.tap_addr  = smp_i.tap_index;
    cmd_n.tap_value = smp_i.tap_value;
    cmd_n.model     = smp_i.model_sample;
    cmd_n.meas      = smp_i.measured_sample;
    cmd_n.last      = smp_i.last_sample;
  end

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cmd_n;
    end
  end

endmodule

### design/ccrf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccrf_back
// Executes queued commands: writes template taps, stores model samples and
// walks one multiply-accumulate over the history, then scales, saturates,
// squares the residual and updates the running sums.
// ----------------------------------------------------------------------------
module ccrf_back import ccrf_pkg::*; #(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       cmd_valid_i,
  output logic       cmd_ready_o,
  input  cmd_t       cmd_i,
  ccrf_out_if.source res_o
);

  localparam int TapDepth = tap_depth(MAX_SAMPLES);
  localparam int TAddrW   = $clog2(TapDepth);
  localparam int HAddrW   = $clog2(MAX_SAMPLES);
  localparam int IdxW     = $clog2(MAX_SAMPLES + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_SHIFT,
    ST_DIFF,
    ST_SQUARE,
    ST_EMIT
  } state_e;

  state_e state_q;

  logic signed [TAP_W-1:0]   tap_mem  [TapDepth];
  logic signed [MODEL_W-1:0] hist_mem [MAX_SAMPLES];
  logic signed [TAP_W-1:0]   tap_rd_q;
  logic signed [MODEL_W-1:0] hist_rd_q;

  logic [IdxW-1:0]          idx_q;
  logic [TAddrW-1:0]        k_q, kmax_q;
  logic                     rd_v_q, prod_v_q;
  logic signed [31:0]       prod_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic signed [MEAS_W-1:0] meas_q;
  logic                     last_q;
  logic signed [CONV_W-1:0] conv_q;
  logic                     sat_q, inwin_q;
  logic [CONV_W:0]          ad_q;
  logic [SQ_W-1:0]          sq_q;
  logic [ACC_W-1:0]         acc_q;
  logic [CNT_W-1:0]         cnt_q;

  logic                     res_valid_q;
  logic signed [CONV_W-1:0] res_conv_q;
  logic                     res_inwin_q, res_sat_q, res_end_q;
  logic [ACC_W-1:0]         res_acc_q;
  logic [CNT_W-1:0]         res_cnt_q;

  logic                     pop, idx_room, rd_en;
  logic                     tap_we, hist_we;
  logic [HAddrW-1:0]        hist_ra;
  logic [TAddrW-1:0]        kmax_n;
  logic signed [SUM_W-1:0]  shifted;
  logic                     sat_hi, sat_lo, inwin_n;
  logic signed [CONV_W-1:0] conv_n;
  logic [CONV_W:0]          diff;
  logic [ACC_W:0]           acc_sum;
  logic [ACC_W-1:0]         acc_n;
  logic [CNT_W-1:0]         cnt_n;

  assign cmd_ready_o = (state_q == ST_IDLE);
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign idx_room    = (32'(idx_q) < MAX_SAMPLES);
  assign tap_we      = pop && cmd_i.is_tap && cmd_i.tap_ok;
  assign hist_we     = pop && !cmd_i.is_tap && idx_room;
  assign rd_en       = (state_q == ST_MAC);
  assign hist_ra     = idx_q[HAddrW-1:0] - HAddrW'(k_q);
  assign kmax_n      = (32'(idx_q) < TapDepth - 1) ? TAddrW'(idx_q)
                                                   : TAddrW'(TapDepth - 1);

  always_ff @(posedge clk_i) begin
    if (tap_we) begin
      tap_mem[cmd_i.tap_addr[TAddrW-1:0]] <= cmd_i.tap_value;
    end
    if (rd_en) begin
      tap_rd_q <= tap_mem[k_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[idx_q[HAddrW-1:0]] <= cmd_i.model;
    end
    if (rd_en) begin
      hist_rd_q <= hist_mem[hist_ra];
    end
  end

  always_comb begin
    // Arithmetic shift of the signed sum rounds toward minus infinity.
    shifted = sum_q >>> cfg_i.frac_shift;
    sat_hi  = (shifted > SUM_HI);
    sat_lo  = (shifted < SUM_LO);
    if (sat_hi) begin
      conv_n = CONV_W'(CONV_MAX);
    end else if (sat_lo) begin
      conv_n = CONV_W'(CONV_MIN);
    end else begin
      conv_n = shifted[CONV_W-1:0];
    end
    inwin_n = (32'(idx_q) >= 32'(cfg_i.win_start)) &&
              (32'(idx_q) <= 32'(cfg_i.win_end));
    diff    = {meas_q[MEAS_W-1], meas_q} - {conv_q[CONV_W-1], conv_q};
    acc_sum = {1'b0, acc_q} + (ACC_W + 1)'(sq_q);
    acc_n   = acc_q;
    cnt_n   = cnt_q;
    if (inwin_q) begin
      acc_n = acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
      cnt_n = (cnt_q == {CNT_W{1'b1}}) ? cnt_q : cnt_q + CNT_W'(1);
    end
  end

  assign res_o.valid          = res_valid_q;
  assign res_o.conv_value     = res_conv_q;
  assign res_o.in_window      = res_inwin_q;
  assign res_o.residual_sum   = res_acc_q;
  assign res_o.window_count   = res_cnt_q;
  assign res_o.conv_saturated = res_sat_q;
  assign res_o.pass_end       = res_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      k_q         <= '0;
      kmax_q      <= '0;
      rd_v_q      <= 1'b0;
      prod_v_q    <= 1'b0;
      prod_q      <= '0;
      sum_q       <= '0;
      meas_q      <= '0;
      last_q      <= 1'b0;
      conv_q      <= '0;
      sat_q       <= 1'b0;
      inwin_q     <= 1'b0;
      ad_q        <= '0;
      sq_q        <= '0;
      acc_q       <= '0;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
      res_conv_q  <= '0;
      res_inwin_q <= 1'b0;
      res_sat_q   <= 1'b0;
      res_end_q   <= 1'b0;
      res_acc_q   <= '0;
      res_cnt_q   <= '0;
    end else begin
      // While emitting, the result register is loaded or held below.
      if (res_o.ready && (state_q != ST_EMIT)) begin
        res_valid_q <= 1'b0;
      end

      // Multiply-accumulate pipeline: memory read, product, sum.
      rd_v_q   <= rd_en;
      prod_v_q <= rd_v_q;
      if (rd_v_q) begin
        prod_q <= tap_rd_q * hist_rd_q;
      end
      if (prod_v_q) begin
        sum_q <= sum_q + SUM_W'(prod_q);
      end

      case (state_q)
        ST_IDLE: begin
          if (pop && !cmd_i.is_tap) begin
            meas_q <= cmd_i.meas;
            last_q <= cmd_i.last;
            if (idx_room) begin
              k_q    <= '0;
              kmax_q <= kmax_n;
              sum_q  <= '0;
              state_q <= ST_MAC;
            end else begin
              // History is full: the sample passes through with no sum.
              conv_q  <= '0;
              sat_q   <= 1'b0;
              inwin_q <= 1'b0;
              state_q <= ST_EMIT;
            end
          end
        end
        ST_MAC: begin
          if (k_q == kmax_q) begin
            state_q <= ST_DRAIN;
          end else begin
            k_q <= k_q + TAddrW'(1);
          end
        end
        ST_DRAIN: begin
          if (!rd_v_q && !prod_v_q) begin
            state_q <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          conv_q  <= conv_n;
          sat_q   <= sat_hi || sat_lo;
          inwin_q <= inwin_n;
          state_q <= ST_DIFF;
        end
        ST_DIFF: begin
          ad_q    <= diff[CONV_W] ? -diff : diff;
          state_q <= ST_SQUARE;
        end
        ST_SQUARE: begin
          sq_q    <= ad_q * ad_q;
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!res_valid_q || res_o.ready) begin
            res_valid_q <= 1'b1;
            res_conv_q  <= conv_q;
            res_inwin_q <= inwin_q;
            res_sat_q   <= sat_q;
            res_end_q   <= last_q;
            res_acc_q   <= acc_n;
            res_cnt_q   <= cnt_n;
            if (last_q) begin
              idx_q <= '0;
              acc_q <= '0;
              cnt_q <= '0;
            end else begin
              acc_q <= acc_n;
              cnt_q <= cnt_n;
              if (idx_room) begin
                idx_q <= idx_q + IdxW'(1);
              end
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### dv/causal_convolution_residual_fit_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// causal_convolution_residual_fit_unit_tb
// Self-checking bench for the causal convolution residual fit unit. A short
// directed table covers the field extremes, saturation, an empty window and
// the tap store ends. A template load of the taps that the longest pass
// reaches follows, then several random phases with different window and shift
// settings and idle and stall rates. Result beats are checked against an
// in-bench convolution and residual predictor, or a pinned directed result.
// ----------------------------------------------------------------------------
module causal_convolution_residual_fit_unit_tb;
  import ccrf_pkg::*;

  localparam logic KIND_TAP    = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  localparam int SETTLE_CYCLES   = 16;
  localparam int TAIL_CYCLES     = 64;
  localparam int QUIET_LIMIT     = 20000;
  localparam int ITEMS_PER_PHASE = 56;
  localparam int NUM_PHASES      = 8;
  localparam int RANDOM_PHASE    = 6;
  localparam int PRESSURE_PHASE  = 0;
  localparam int HOLD_CYCLES     = 400;
  localparam int TMPL_LEN        = 100;
  localparam int NUM_ROWS        = 19;

  typedef enum logic [1:0] {
    ROW_TAP,
    ROW_SMP,
    ROW_CFG
  } row_op_e;

  typedef struct {
    logic                      kind;
    logic [TIDX_W-1:0]         tidx;
    logic signed [TAP_W-1:0]   tval;
    logic signed [MODEL_W-1:0] model;
    logic signed [MEAS_W-1:0]  meas;
    logic                      last;
  } smp_beat_t;

  typedef struct {
    logic signed [CONV_W-1:0] conv;
    logic                     in_win;
    logic [ACC_W-1:0]         rsum;
    logic [CNT_W-1:0]         count;
    logic                     sat;
    logic                     pend;
  } fit_result_t;

  // arg0: tap index, model sample or register index.
  // arg1: tap value, measured sample or register value.
  typedef struct {
    row_op_e     op;
    int          arg0;
    int          arg1;
    logic        last;
    logic        pinned;
    fit_result_t want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  ccrf_in_if  smp ();
  ccrf_out_if res ();
  ccrf_cfg_if cfg ();

  causal_convolution_residual_fit_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .smp_i  (smp),
    .res_o  (res),
    .cfg_i  (cfg)
  );

  // Predictor state.
  logic signed [TAP_W-1:0]   tmpl_taps  [TAP_REACH];
  logic signed [MODEL_W-1:0] model_hist [MAX_SAMPLES_DEF];
  int unsigned               sample_pos;
  logic [ACC_W-1:0]          sq_sum;
  logic [CNT_W-1:0]          win_count;
  logic [WIN_W-1:0]          win_lo;
  logic [WIN_W-1:0]          win_hi;
  logic [SHIFT_W-1:0]        shift_amt;

  fit_result_t pending_fits [$];
  fit_result_t unpinned;
  stim_row_t   directed_rows [NUM_ROWS];

  int mismatches;
  int src_idle_pct;
  int stall_pct;
  int hold_left;
  int quiet_cycles;
  int pass_left;

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic fit_result_t convolve_sample(smp_beat_t b);
    longint      acc;
    longint      conv;
    longint      diff;
    logic [63:0] sq;
    int unsigned j;
    fit_result_t r;
    acc      = 0;
    r.conv   = '0;
    r.in_win = 1'b0;
    r.sat    = 1'b0;
    r.pend   = b.last;
    if (sample_pos < MAX_SAMPLES_DEF) begin
      model_hist[sample_pos] = b.model;
      for (j = 0; j <= sample_pos; j++) begin
        acc += longint'(model_hist[j]) * longint'(tmpl_taps[sample_pos - j]);
      end
      conv = acc >>> shift_amt;
      if (conv > CONV_MAX) begin
        conv  = CONV_MAX;
        r.sat = 1'b1;
      end else if (conv < CONV_MIN) begin
        conv  = CONV_MIN;
        r.sat = 1'b1;
      end
      r.conv = CONV_W'(conv);
      if (sample_pos >= win_lo && sample_pos <= win_hi) begin
        diff = longint'(b.meas) - conv;
        if (diff < 0) diff = -diff;
        sq       = 64'(diff * diff);
        r.in_win = 1'b1;
        if (sq > ({1'b0, {ACC_W{1'b1}}} - {1'b0, sq_sum})) sq_sum = '1;
        else sq_sum = sq_sum + ACC_W'(sq);
        if (win_count != '1) win_count = win_count + 1'b1;
      end
      sample_pos++;
    end
    r.rsum  = sq_sum;
    r.count = win_count;
    if (b.last) begin
      sample_pos = 0;
      sq_sum     = '0;
      win_count  = '0;
    end
    return r;
  endfunction

  function automatic logic signed [15:0] rand_q15();
    case ($urandom_range(0, 9))
      0: return TAP_W'($urandom);
      1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default: return TAP_W'(int'($urandom_range(0, 8191)) - 4096);
    endcase
  endfunction

  function automatic smp_beat_t make_tap(int unsigned idx);
    smp_beat_t b;
    b.kind  = KIND_TAP;
    b.tidx  = TIDX_W'(idx);
    b.tval  = rand_q15();
    b.model = MODEL_W'($urandom);
    b.meas  = MEAS_W'($urandom);
    b.last  = 1'($urandom);
    return b;
  endfunction

  function automatic smp_beat_t make_sample(logic last);
    smp_beat_t b;
    b.kind  = KIND_SAMPLE;
    b.tidx  = TIDX_W'($urandom);
    b.tval  = TAP_W'($urandom);
    b.model = rand_q15();
    case ($urandom_range(0, 9))
      0: b.meas = MEAS_W'($urandom);
      1: b.meas = $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
      default: b.meas = MEAS_W'(int'($urandom_range(0, 131071)) - 65536);
    endcase
    b.last = last;
    return b;
  endfunction

  function automatic void match_field(string name, logic signed [63:0] want,
                                      logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Leaves valid high after the beat is taken; the caller either sends the
  // next beat in the same step or drops valid.
  task automatic push_beat(smp_beat_t b, logic pinned, fit_result_t want);
    fit_result_t pred;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      smp.valid <= 1'b0;
      @(posedge clk_i);
    end
    smp.valid           <= 1'b1;
    smp.kind            <= b.kind;
    smp.tap_index       <= b.tidx;
    smp.tap_value       <= b.tval;
    smp.model_sample    <= b.model;
    smp.measured_sample <= b.meas;
    smp.last_sample     <= b.last;
    do @(posedge clk_i); while (smp.ready !== 1'b1);
    if (b.kind == KIND_SAMPLE) begin
      pred = convolve_sample(b);
      pending_fits.push_back(pinned ? want : pred);
    end else begin
      tmpl_taps[b.tidx] = b.tval;
    end
  endtask

  task automatic cfg_write(cfg_idx_e which, int unsigned value);
    cfg.valid <= 1'b1;
    cfg.index <= which;
    cfg.wdata <= CFG_DATA_W'(value);
    do @(posedge clk_i); while (cfg.ready !== 1'b1);
    case (which)
      CFG_WIN_START:  win_lo    = WIN_W'(value);
      CFG_WIN_END:    win_hi    = WIN_W'(value);
      CFG_FRAC_SHIFT: shift_amt = SHIFT_W'(value);
      default: ;
    endcase
  endtask

  // Tap loads return nothing, so a settling wait follows the last result
  // before the block counts as idle.
  task automatic settle_idle();
    smp.valid <= 1'b0;
    while (pending_fits.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_settings(int unsigned ws, int unsigned we, int unsigned fs);
    settle_idle();
    cfg_write(CFG_WIN_START, ws);
    cfg_write(CFG_WIN_END, we);
    cfg_write(CFG_FRAC_SHIFT, fs);
    cfg.valid <= 1'b0;
  endtask

  // Result checker.
  always @(posedge clk_i) begin
    fit_result_t want;
    if (rst_ni && res.valid === 1'b1 && res.ready === 1'b1) begin
      if (pending_fits.size() == 0) begin
        $error("result beat with no expected result waiting");
        mismatches++;
      end else begin
        want = pending_fits.pop_front();
        match_field("conv_value", want.conv, res.conv_value);
        match_field("in_window", want.in_win, res.in_window);
        match_field("residual_sum", want.rsum, res.residual_sum);
        match_field("window_count", want.count, res.window_count);
        match_field("conv_saturated", want.sat, res.conv_saturated);
        match_field("pass_end", want.pend, res.pass_end);
      end
    end
  end

  // Result side: random stalls, plus a long hold-off when asked for.
  initial begin
    res.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        res.ready <= 1'b0;
        hold_left--;
      end else begin
        res.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Watchdog on cycles without any beat on any channel.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((smp.valid && smp.ready) || (res.valid && res.ready) ||
          (cfg.valid && cfg.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int          ws [NUM_PHASES];
    int          we [NUM_PHASES];
    int          fs [NUM_PHASES];
    int          idle_tab [NUM_PHASES];
    int          stall_tab [NUM_PHASES];
    int          k;
    smp_beat_t   b;
    stim_row_t   row;

    ws        = '{0, 0, 1023, 5, 30, 3, 0, 0};
    we        = '{1023, 0, 1023, 40, 10, 60, 0, 1023};
    fs        = '{12, 0, 15, 8, 4, 13, 0, 10};
    idle_tab  = '{0, 68, 0, 15, 68, 0, 0, 15};
    stall_tab = '{0, 0, 68, 15, 0, 68, 0, 15};

    directed_rows = '{
      '{ROW_TAP, 0, 4096, 1'b0, 1'b0, '{0, 0, 0, 0, 0, 0}},
      '{ROW_SMP, 100, 103, 1'b1, 1'b1, '{24'sd100, 1'b1, 63'd9, 11'd1, 1'b0, 1'b1}},
      '{ROW_CFG, CFG_FRAC_SHIFT, 0, 1'b0, 1'b0, '{0, 0, 0, 0, 0, 0}},
      '{ROW_TAP, 0, 32767, 1'b0, 1'b0, '{0, 0, 0, 0, 0, 0}},
      '{ROW_TAP, 1, 32767, 1'b0, 1'b0, '{0, 0, 0, 0, 0, 0}},
      '{ROW_TAP, 2, -32768, 1'b0, 1'b0, '{0, 0, 0, 0, 0, 0}},
      '{ROW_SMP, 32767, 0, 1'b0, 1'b1,
        '{24'sd8388607, 1'b1, 63'd70368727400449, 11'd1, 1'b1, 1'b0}},
      '{ROW_SMP, -32768, 8388607, 1'b0, 1'b0, '{0, 0, 0, 0, 0, 0}},
      '{ROW_SMP, -32768, -8388608, 1'b1, 1'b0, '{0, 0, 0, 0, 0, 0}},
      '{ROW_CFG, CFG_WIN_START, 1, 1'b0, 1'b0, '{0, 0, 0, 0, 0, 0}},
      '{ROW_CFG, CFG_WIN_END, 0, 1'b0, 1'b0, '{0, 0, 0, 0, 0, 0}},
      '{ROW_SMP, 5, 5, 1'b0, 1'b1, '{24'sd163835, 1'b0, 63'd0, 11'd0, 1'b0, 1'b0}},
      '{ROW_SMP, 0, -1, 1'b1, 1'b0, '{0, 0, 0, 0, 0, 0}},
      '{ROW_CFG, CFG_WIN_END, 1023, 1'b0, 1'b0, '{0, 0, 0, 0, 0, 0}},
      '{ROW_CFG, CFG_FRAC_SHIFT, 15, 1'b0, 1'b0, '{0, 0, 0, 0, 0, 0}},
      '{ROW_TAP, 1023, -1, 1'b0, 1'b0, '{0, 0, 0, 0, 0, 0}},
      '{ROW_SMP, -1, 0, 1'b0, 1'b0, '{0, 0, 0, 0, 0, 0}},
      '{ROW_SMP, 32767, 8388607, 1'b1, 1'b0, '{0, 0, 0, 0, 0, 0}},
      '{ROW_CFG, CFG_WIN_START, 0, 1'b0, 1'b0, '{0, 0, 0, 0, 0, 0}}
    };

    mismatches   = 0;
    src_idle_pct = 0;
    stall_pct    = 0;
    hold_left    = 0;
    quiet_cycles = 0;
    pass_left    = 0;
    sample_pos   = 0;
    sq_sum       = '0;
    win_count    = '0;
    win_lo       = '0;
    win_hi       = 10'd1023;
    shift_amt    = 4'd12;

    rst_ni              <= 1'b0;
    smp.valid           <= 1'b0;
    smp.kind            <= KIND_TAP;
    smp.tap_index       <= '0;
    smp.tap_value       <= '0;
    smp.model_sample    <= '0;
    smp.measured_sample <= '0;
    smp.last_sample     <= 1'b0;
    cfg.valid           <= 1'b0;
    cfg.index           <= CFG_WIN_START;
    cfg.wdata           <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows run at the reset settings until the first register row.
    for (int r = 0; r < NUM_ROWS; r++) begin
      row = directed_rows[r];
      case (row.op)
        ROW_CFG: begin
          settle_idle();
          cfg_write(cfg_idx_e'(row.arg0), row.arg1);
          cfg.valid <= 1'b0;
        end
        default: begin
          b.kind  = (row.op == ROW_SMP) ? KIND_SAMPLE : KIND_TAP;
          b.tidx  = (row.op == ROW_TAP) ? TIDX_W'(row.arg0) : '0;
          b.tval  = (row.op == ROW_TAP) ? TAP_W'(row.arg1) : '0;
          b.model = (row.op == ROW_SMP) ? MODEL_W'(row.arg0) : '0;
          b.meas  = (row.op == ROW_SMP) ? MEAS_W'(row.arg1) : '0;
          b.last  = row.last;
          push_beat(b, row.pinned, row.want);
        end
      endcase
    end

    // Every tap that the longest pass reaches, so that no later sample reads
    // an unwritten tap.
    for (int t = 0; t < TMPL_LEN; t++) push_beat(make_tap(t), 1'b0, unpinned);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == RANDOM_PHASE) begin
        apply_settings($urandom_range(0, 63), $urandom_range(0, 1023),
                       $urandom_range(0, 15));
      end else begin
        apply_settings(ws[p], we[p], fs[p]);
      end
      src_idle_pct = idle_tab[p];
      stall_pct    = stall_tab[p];
      if (p == PRESSURE_PHASE) hold_left = HOLD_CYCLES;
      k = 0;
      while (k < ITEMS_PER_PHASE || pass_left != 0) begin
        if ($urandom_range(0, 99) < 15) begin
          // Tap reloads land in the middle of passes as well.
          push_beat(make_tap($urandom_range(0, TAP_REACH - 1)), 1'b0, unpinned);
        end else begin
          if (pass_left == 0) begin
            pass_left = ($urandom_range(0, 4) == 0) ? $urandom_range(25, TMPL_LEN)
                                                    : $urandom_range(1, 24);
          end
          push_beat(make_sample(pass_left == 1), 1'b0, unpinned);
          pass_left--;
        end
        k++;
      end
    end

    smp.valid <= 1'b0;
    while (pending_fits.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_fits.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### filelist.f
design/ccrf_pkg.sv
design/ccrf_if.sv
design/ccrf_front.sv
design/ccrf_back.sv
design/causal_convolution_residual_fit_unit.sv
dv/causal_convolution_residual_fit_unit_tb.sv
